// ===== rtl/fpl_pkg.sv =====
// ----------------------------------------------------------------------------
// fpl_pkg - feeder position loop shared definitions
// Sequencer states, register map, reset values and the MAC control group.
// ----------------------------------------------------------------------------
package fpl_pkg;

  localparam int COUNTS_PER_TURN_DEF = 8192;
  localparam int STUCK_TICKS_DEF     = 100;
  localparam int REVERSE_TICKS_DEF   = 500;

  localparam int SLOW_SPEED = 60;

  localparam int GAIN_W = 24;
  localparam int OP_W   = 34;
  localparam int LO_W   = 17;
  localparam int ACC_W  = 62;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [23:0] OUTER_GAIN_RST    = 24'd5243;
  localparam logic [23:0] INNER_GAIN_RST    = 24'd393216;
  localparam logic [23:0] INNER_INT_RST     = 24'd0;
  localparam logic [14:0] INTEGRAL_LIM_RST  = 15'd2500;
  localparam logic [14:0] OUTPUT_LIM_RST    = 15'd9999;
  localparam logic [15:0] RAMP_STEP_RST     = 16'd922;
  localparam logic [17:0] SHOT_ANGLE_RST    = 18'd36864;
  localparam logic [14:0] STUCK_LEVEL_RST   = 15'd500;

  typedef enum logic [2:0] {
    REG_OUTER_GAIN   = 3'd0,
    REG_INNER_GAIN   = 3'd1,
    REG_INNER_INT    = 3'd2,
    REG_INTEGRAL_LIM = 3'd3,
    REG_OUTPUT_LIM   = 3'd4,
    REG_RAMP_STEP    = 3'd5,
    REG_SHOT_ANGLE   = 3'd6,
    REG_STUCK_LEVEL  = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RAMP,
    ST_JAM,
    ST_ERR,
    ST_OUT_LO,
    ST_OUT_HI,
    ST_OUTER,
    ST_INT_LO,
    ST_INT_HI,
    ST_INTEG,
    ST_DRV_LO,
    ST_DRV_HI,
    ST_DRIVE
  } state_t;

  typedef struct packed {
    logic load_lo;
    logic add_hi;
  } mac_ctrl_t;

endpackage

// ===== rtl/feeder_position_loop_jam_recovery.sv =====
// ----------------------------------------------------------------------------
// feeder_position_loop_jam_recovery - feeder position loop with jam recovery
// Per tick: resync/shot, target ramp, jam watch, angle unwrap, outer P loop,
// inner PI loop with clamped integral and clamped drive.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------
//   in      | input     | in_valid / in_stall       | angle speed shot_request resync
//   out     | output    | out_valid / out_stall     | drive jam_active jam_count
//   cfg     | input     | psel penable pwrite pready| paddr pwdata prdata
//
// One word per 13 sequencer steps after accept, the last waiting on out_stall;
// three 34x24 products each take two passes through one shared 18x25 multiplier.
// in_stall is high from accept until the result is loaded into the output
// register; the next word is taken while that result waits on out_stall.
// Synchronous reset restores register defaults and clears all loop state.
// ----------------------------------------------------------------------------
module feeder_position_loop_jam_recovery #(
  parameter int COUNTS_PER_TURN = fpl_pkg::COUNTS_PER_TURN_DEF,
  parameter int STUCK_TICKS     = fpl_pkg::STUCK_TICKS_DEF,
  parameter int REVERSE_TICKS   = fpl_pkg::REVERSE_TICKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [12:0]                   angle,
  input  logic signed [15:0]            speed,
  input  logic                          shot_request,
  input  logic                          resync,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            drive,
  output logic                          jam_active,
  output logic [15:0]                   jam_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpl_pkg::ADDR_W-1:0]    paddr,
  input  logic [fpl_pkg::DATA_W-1:0]    pwdata,
  output logic [fpl_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int OP_W    = fpl_pkg::OP_W;
  localparam int ACC_W   = fpl_pkg::ACC_W;
  localparam int GAIN_W  = fpl_pkg::GAIN_W;
  localparam int DATA_W  = fpl_pkg::DATA_W;
  localparam int CPT_LOG = $clog2(COUNTS_PER_TURN) + 2;
  localparam int D_W     = (CPT_LOG > 15) ? CPT_LOG : 15;
  localparam int STUCK_W = $clog2(STUCK_TICKS + 1);
  localparam int REV_W   = $clog2(REVERSE_TICKS + 1);

  localparam logic signed [D_W-1:0] CNT_S  = D_W'(COUNTS_PER_TURN);
  localparam logic signed [D_W-1:0] HALF_S = D_W'(COUNTS_PER_TURN / 2 - 1);
  localparam logic [STUCK_W-1:0]    STUCK_LIM = STUCK_W'(STUCK_TICKS);
  localparam logic [REV_W-1:0]      REV_LIM   = REV_W'(REVERSE_TICKS);

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] S32_MAX  = $signed({{(ACC_W-31){1'b0}}, {31{1'b1}}});
  localparam logic signed [ACC_W-1:0] S32_MIN  = $signed({{(ACC_W-31){1'b1}}, 31'b0});

  // configuration
  logic [23:0] outer_gain, inner_gain, inner_int_gain;
  logic [14:0] integral_limit, output_limit, stuck_drive_level;
  logic [15:0] ramp_step;
  logic [17:0] shot_angle;

  // loop state
  logic [31:0]        turn_sum, target_pos, buffered_target;
  logic [12:0]        prev_angle;
  logic signed [31:0] inner_integral;
  logic signed [15:0] last_drive;
  logic [STUCK_W-1:0] stuck_ticks;
  logic [REV_W-1:0]   reverse_ticks;
  logic               jam_flag;
  logic [15:0]        jam_total;

  // captured word
  logic [12:0]        angle_r;
  logic signed [15:0] speed_r;
  logic               shot_r, resync_r;

  fpl_pkg::state_t state, state_next;
  fpl_pkg::mac_ctrl_t mac_ctrl;
  logic signed [OP_W-1:0]  op;
  logic        [GAIN_W-1:0] mac_gain;
  logic signed [ACC_W-1:0] acc_init, acc;
  logic in_accept, out_free, cfg_write;
  fpl_pkg::reg_idx_t cfg_idx;

  // datapath combinational terms
  logic signed [32:0]      ramp_diff, ramp_step_s, ramp_clamped;
  logic [31:0]             turn_back;
  logic [15:0]             abs_drive;
  logic signed [16:0]      speed_17, abs_speed;
  logic                    stuck_hit;
  logic signed [D_W-1:0]   ang_d, ang_step;
  logic signed [32:0]      err_33;
  logic signed [ACC_W-1:0] acc_rnd, int_lim, int_clamped, out_lim, drv_clamped;
  logic signed [31:0]      outer_sat;
  logic signed [OP_W-1:0]  ierr;

  fpl_mac u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .op       (op),
    .gain     (mac_gain),
    .acc_init (acc_init),
    .acc      (acc)
  );

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = fpl_pkg::reg_idx_t'(paddr[4:2]);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    unique case (cfg_idx)
      fpl_pkg::REG_OUTER_GAIN:   prdata = DATA_W'(outer_gain);
      fpl_pkg::REG_INNER_GAIN:   prdata = DATA_W'(inner_gain);
      fpl_pkg::REG_INNER_INT:    prdata = DATA_W'(inner_int_gain);
      fpl_pkg::REG_INTEGRAL_LIM: prdata = DATA_W'(integral_limit);
      fpl_pkg::REG_OUTPUT_LIM:   prdata = DATA_W'(output_limit);
      fpl_pkg::REG_RAMP_STEP:    prdata = DATA_W'(ramp_step);
      fpl_pkg::REG_SHOT_ANGLE:   prdata = DATA_W'(shot_angle);
      fpl_pkg::REG_STUCK_LEVEL:  prdata = DATA_W'(stuck_drive_level);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_gain        <= fpl_pkg::OUTER_GAIN_RST;
      inner_gain        <= fpl_pkg::INNER_GAIN_RST;
      inner_int_gain    <= fpl_pkg::INNER_INT_RST;
      integral_limit    <= fpl_pkg::INTEGRAL_LIM_RST;
      output_limit      <= fpl_pkg::OUTPUT_LIM_RST;
      ramp_step         <= fpl_pkg::RAMP_STEP_RST;
      shot_angle        <= fpl_pkg::SHOT_ANGLE_RST;
      stuck_drive_level <= fpl_pkg::STUCK_LEVEL_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        fpl_pkg::REG_OUTER_GAIN:   outer_gain        <= pwdata[23:0];
        fpl_pkg::REG_INNER_GAIN:   inner_gain        <= pwdata[23:0];
        fpl_pkg::REG_INNER_INT:    inner_int_gain    <= pwdata[23:0];
        fpl_pkg::REG_INTEGRAL_LIM: integral_limit    <= pwdata[14:0];
        fpl_pkg::REG_OUTPUT_LIM:   output_limit      <= pwdata[14:0];
        fpl_pkg::REG_RAMP_STEP:    ramp_step         <= pwdata[15:0];
        fpl_pkg::REG_SHOT_ANGLE:   shot_angle        <= pwdata[17:0];
        fpl_pkg::REG_STUCK_LEVEL:  stuck_drive_level <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != fpl_pkg::ST_IDLE);
    mac_ctrl   = '0;
    mac_gain   = outer_gain;
    acc_init   = $signed({{(ACC_W-32){inner_integral[31]}}, inner_integral});
    unique case (state)
      fpl_pkg::ST_IDLE:   if (in_valid) state_next = fpl_pkg::ST_LOAD;
      fpl_pkg::ST_LOAD:   state_next = fpl_pkg::ST_RAMP;
      fpl_pkg::ST_RAMP:   state_next = fpl_pkg::ST_JAM;
      fpl_pkg::ST_JAM:    state_next = fpl_pkg::ST_ERR;
      fpl_pkg::ST_ERR:    state_next = fpl_pkg::ST_OUT_LO;
      fpl_pkg::ST_OUT_LO: begin
        mac_ctrl.load_lo = 1'b1;
        acc_init         = '0;
        state_next       = fpl_pkg::ST_OUT_HI;
      end
      fpl_pkg::ST_OUT_HI: begin
        mac_ctrl.add_hi = 1'b1;
        state_next      = fpl_pkg::ST_OUTER;
      end
      fpl_pkg::ST_OUTER:  state_next = fpl_pkg::ST_INT_LO;
      fpl_pkg::ST_INT_LO: begin
        mac_ctrl.load_lo = 1'b1;
        mac_gain         = inner_int_gain;
        state_next       = fpl_pkg::ST_INT_HI;
      end
      fpl_pkg::ST_INT_HI: begin
        mac_ctrl.add_hi = 1'b1;
        mac_gain        = inner_int_gain;
        state_next      = fpl_pkg::ST_INTEG;
      end
      fpl_pkg::ST_INTEG:  state_next = fpl_pkg::ST_DRV_LO;
      fpl_pkg::ST_DRV_LO: begin
        mac_ctrl.load_lo = 1'b1;
        mac_gain         = inner_gain;
        state_next       = fpl_pkg::ST_DRV_HI;
      end
      fpl_pkg::ST_DRV_HI: begin
        mac_ctrl.add_hi = 1'b1;
        mac_gain        = inner_gain;
        state_next      = fpl_pkg::ST_DRIVE;
      end
      fpl_pkg::ST_DRIVE:  if (out_free) state_next = fpl_pkg::ST_IDLE;
      default:            state_next = fpl_pkg::ST_IDLE;
    endcase
  end

  // datapath terms
  always_comb begin
    ramp_diff   = $signed({buffered_target[31], buffered_target})
                - $signed({target_pos[31], target_pos});
    ramp_step_s = $signed({17'b0, ramp_step});
    if (ramp_diff > ramp_step_s) begin
      ramp_clamped = ramp_step_s;
    end else if (ramp_diff < -ramp_step_s) begin
      ramp_clamped = -ramp_step_s;
    end else begin
      ramp_clamped = ramp_diff;
    end

    turn_back = turn_sum - {14'b0, shot_angle};
    abs_drive = last_drive[15] ? 16'(-last_drive) : 16'(last_drive);
    speed_17  = $signed({speed_r[15], speed_r});
    abs_speed = speed_17[16] ? -speed_17 : speed_17;
    stuck_hit = (abs_drive >= {1'b0, stuck_drive_level})
             && (abs_speed <= $signed(17'(fpl_pkg::SLOW_SPEED)));

    ang_d = $signed({{(D_W-13){1'b0}}, angle_r}) - $signed({{(D_W-13){1'b0}}, prev_angle});
    if (ang_d > HALF_S) begin
      ang_step = ang_d - CNT_S;
    end else if (ang_d < -HALF_S) begin
      ang_step = ang_d + CNT_S;
    end else begin
      ang_step = ang_d;
    end

    err_33 = $signed({target_pos[31], target_pos}) - $signed({turn_sum[31], turn_sum});

    acc_rnd = (acc + RND_HALF) >>> 16;
    if (acc_rnd > S32_MAX) begin
      outer_sat = 32'sh7FFF_FFFF;
    end else if (acc_rnd < S32_MIN) begin
      outer_sat = 32'sh8000_0000;
    end else begin
      outer_sat = acc_rnd[31:0];
    end
    ierr = $signed({{(OP_W-32){outer_sat[31]}}, outer_sat})
         - $signed({{(OP_W-16){speed_r[15]}}, speed_r});

    int_lim = $signed({{(ACC_W-31){1'b0}}, integral_limit, 16'b0});
    if (acc > int_lim) begin
      int_clamped = int_lim;
    end else if (acc < -int_lim) begin
      int_clamped = -int_lim;
    end else begin
      int_clamped = acc;
    end

    out_lim = $signed({{(ACC_W-15){1'b0}}, output_limit});
    if (acc_rnd > out_lim) begin
      drv_clamped = out_lim;
    end else if (acc_rnd < -out_lim) begin
      drv_clamped = -out_lim;
    end else begin
      drv_clamped = acc_rnd;
    end
  end

  // input capture and MAC operand, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      angle_r  <= angle;
      speed_r  <= speed;
      shot_r   <= shot_request;
      resync_r <= resync;
    end
    if (state == fpl_pkg::ST_ERR) begin
      op <= $signed({err_33[32], err_33});
    end else if (state == fpl_pkg::ST_OUTER) begin
      op <= ierr;
    end
  end

  // loop state and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_sum        <= '0;
      prev_angle      <= '0;
      target_pos      <= '0;
      buffered_target <= '0;
      inner_integral  <= '0;
      last_drive      <= '0;
      stuck_ticks     <= '0;
      reverse_ticks   <= '0;
      jam_flag        <= 1'b0;
      jam_total       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (state == fpl_pkg::ST_DRIVE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        fpl_pkg::ST_LOAD: begin
          if (resync_r) begin
            turn_sum        <= {19'b0, angle_r};
            prev_angle      <= angle_r;
            target_pos      <= {19'b0, angle_r};
            buffered_target <= {19'b0, angle_r};
          end else if (shot_r) begin
            buffered_target <= buffered_target + {14'b0, shot_angle};
          end
        end
        fpl_pkg::ST_RAMP: begin
          target_pos <= target_pos + ramp_clamped[31:0];
        end
        fpl_pkg::ST_JAM: begin
          if (jam_flag) begin
            if (reverse_ticks >= REV_LIM) begin
              target_pos      <= turn_sum;
              buffered_target <= turn_sum;
              jam_flag        <= 1'b0;
              reverse_ticks   <= '0;
            end else begin
              reverse_ticks <= reverse_ticks + REV_W'(1);
            end
          end else if (stuck_hit) begin
            if (stuck_ticks >= STUCK_LIM) begin
              target_pos      <= turn_back;
              buffered_target <= turn_back;
              stuck_ticks     <= '0;
              jam_flag        <= 1'b1;
              if (jam_total != 16'hFFFF) jam_total <= jam_total + 16'd1;
            end else begin
              stuck_ticks <= stuck_ticks + STUCK_W'(1);
            end
          end else begin
            stuck_ticks <= '0;
          end
          turn_sum   <= turn_sum + {{(32-D_W){ang_step[D_W-1]}}, ang_step};
          prev_angle <= angle_r;
        end
        fpl_pkg::ST_INTEG: begin
          inner_integral <= int_clamped[31:0];
        end
        fpl_pkg::ST_DRIVE: begin
          if (out_free) begin
            last_drive <= drv_clamped[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  // output payload, no reset
  always_ff @(posedge clk) begin
    if (state == fpl_pkg::ST_DRIVE && out_free) begin
      drive      <= drv_clamped[15:0];
      jam_active <= jam_flag;
      jam_count  <= jam_total;
    end
  end

endmodule

// ===== rtl/fpl_mac.sv =====
// ----------------------------------------------------------------------------
// fpl_mac - shared two-pass multiply-accumulate
// 34-bit signed operand times 24-bit unsigned gain on one 18x25 multiplier:
// low 17 bits first (loads acc_init plus product), high part second.
// ----------------------------------------------------------------------------
module fpl_mac (
  input  logic                                 clk,
  input  fpl_pkg::mac_ctrl_t                   ctrl,
  input  logic signed [fpl_pkg::OP_W-1:0]      op,
  input  logic        [fpl_pkg::GAIN_W-1:0]    gain,
  input  logic signed [fpl_pkg::ACC_W-1:0]     acc_init,
  output logic signed [fpl_pkg::ACC_W-1:0]     acc
);

  localparam int LO_W   = fpl_pkg::LO_W;
  localparam int OP_W   = fpl_pkg::OP_W;
  localparam int GAIN_W = fpl_pkg::GAIN_W;
  localparam int ACC_W  = fpl_pkg::ACC_W;
  localparam int A_W    = OP_W - LO_W + 1;
  localparam int PROD_W = A_W + GAIN_W + 1;

  logic signed [A_W-1:0]    mul_a;
  logic signed [GAIN_W:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;

  always_comb begin
    if (ctrl.add_hi) begin
      mul_a = $signed({op[OP_W-1], op[OP_W-1:LO_W]});
    end else begin
      mul_a = $signed({{(A_W-LO_W){1'b0}}, op[LO_W-1:0]});
    end
    mul_b    = $signed({1'b0, gain});
    prod     = mul_a * mul_b;
    prod_ext = $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_lo) begin
      acc <= acc_init + prod_ext;
    end else if (ctrl.add_hi) begin
      acc <= acc + (prod_ext <<< LO_W);
    end
  end

endmodule
